FILE: design/bmpp_pkg.sv
// Shared types, codes and pixel mapping helpers for the bicolor matrix pixel plotter.
package bmpp_pkg;

    localparam int NUM_CHIPS_DEF      = 8;
    localparam int WORDS_PER_CHIP_DEF = 64;
    localparam int PLANE_WORDS        = 32;
    localparam int CHIP_IDX_W         = 3;
    localparam int WORD_W             = 5;
    localparam int NIBBLE_W           = 4;
    localparam int CFG_DATA_W         = 6;
    localparam int CFG_IDX_W          = 1;

    localparam logic REQ_PLOT   = 1'b0;
    localparam logic REQ_READ   = 1'b1;
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 1'd1;

    typedef struct packed {
        logic       req_type;
        logic [5:0] x;
        logic [3:0] y;
        logic [1:0] color;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [3:0] chip;
        logic [5:0] word_address;
        logic [3:0] nibble;
        logic [1:0] pixel_color;
        logic       last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_RED
    } state_t;

    // Zero-based chip number: one chip per 16 columns in each half, lower rows add two.
    function automatic logic [CHIP_IDX_W-1:0] chip_index(input logic [5:0] x,
                                                         input logic [3:0] y);
        logic [CHIP_IDX_W-1:0] c;
        c = {1'b0, x[5:4]};
        if (x[5])
            c = c + 3'd2;
        if (y[3])
            c = c + 3'd2;
        return c;
    endfunction

    function automatic logic [WORD_W-1:0] word_index(input logic [5:0] x,
                                                     input logic [3:0] y);
        return {x[3:0], y[2]};
    endfunction

    function automatic logic [NIBBLE_W-1:0] bit_mask(input logic [3:0] y);
        return 4'b1000 >> y[1:0];
    endfunction

endpackage

FILE: design/bmpp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module bmpp_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

FILE: design/bmpp_ctrl.sv
// Request sequencer: clear pass, shadow read-modify-write and result generation.
module bmpp_ctrl #(
    parameter int NUM_CHIPS = bmpp_pkg::NUM_CHIPS_DEF,
    parameter int AW        = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  bmpp_pkg::in_item_t   request,
    input  logic [5:0]           max_x,
    input  logic [3:0]           max_y,
    output logic [AW-1:0]        raddr,
    input  logic [3:0]           rdata_green,
    input  logic [3:0]           rdata_red,
    output logic                 we,
    output logic [AW-1:0]        waddr,
    output logic [3:0]           wdata_green,
    output logic [3:0]           wdata_red,
    output logic                 result_strobe,
    output bmpp_pkg::out_item_t  result
);
    import bmpp_pkg::*;

    localparam int DEPTH = NUM_CHIPS * PLANE_WORDS;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CHIP_IDX_W:0] NUM_CHIPS_L = (CHIP_IDX_W + 1)'(NUM_CHIPS);

    state_t                state_reg, state_next;
    logic [AW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic                  strobe_reg, strobe_next;
    out_item_t             result_reg, result_next;

    in_item_t              req_reg;
    logic [CHIP_IDX_W-1:0] chip_reg;
    logic [WORD_W-1:0]     word_reg;
    logic [NIBBLE_W-1:0]   mask_reg;
    logic                  in_range_reg;
    logic                  chip_ok_reg;
    logic [NIBBLE_W-1:0]   red_nib_reg, red_nib_next;

    logic                  accept;
    logic [CHIP_IDX_W-1:0] in_chip;
    logic [WORD_W-1:0]     in_word;
    logic [1:0]            stored;
    logic [3:0]            new_green, new_red;

    assign accept  = start && (state_reg == ST_IDLE);
    assign busy    = (state_reg != ST_IDLE);
    assign in_chip = chip_index(request.x, request.y);
    assign in_word = word_index(request.x, request.y);
    // Issue the read straight from the request so data lands in the cycle after accept.
    assign raddr   = AW'({in_chip, in_word});

    assign stored    = chip_ok_reg ? {|(rdata_red & mask_reg), |(rdata_green & mask_reg)}
                                   : 2'd0;
    assign new_green = req_reg.color[0] ? (rdata_green | mask_reg) : (rdata_green & ~mask_reg);
    assign new_red   = req_reg.color[1] ? (rdata_red | mask_reg) : (rdata_red & ~mask_reg);

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        strobe_next  = 1'b0;
        result_next  = result_reg;
        red_nib_next = red_nib_reg;
        we           = 1'b0;
        waddr        = AW'({chip_reg, word_reg});
        wdata_green  = new_green;
        wdata_red    = new_red;

        unique case (state_reg)
            ST_CLEAR:
            begin
                we           = 1'b1;
                waddr        = clr_cnt_reg;
                wdata_green  = '0;
                wdata_red    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_ADDR)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                state_next = ST_IDLE;
                if (req_reg.req_type == REQ_READ)
                begin
                    strobe_next             = 1'b1;
                    result_next.kind        = KIND_READ;
                    result_next.chip        = '0;
                    result_next.word_address = '0;
                    result_next.nibble      = '0;
                    result_next.pixel_color = stored;
                    result_next.last        = 1'b1;
                end
                else if (in_range_reg && chip_ok_reg && (stored != req_reg.color))
                begin
                    // Write back both planes now, emit green, hold red for next cycle.
                    we                       = 1'b1;
                    strobe_next              = 1'b1;
                    result_next.kind         = KIND_WRITE;
                    result_next.chip         = {1'b0, chip_reg} + 4'd1;
                    result_next.word_address = {1'b0, word_reg};
                    result_next.nibble       = new_green;
                    result_next.pixel_color  = 2'd0;
                    result_next.last         = 1'b0;
                    red_nib_next             = new_red;
                    state_next               = ST_RED;
                end
            end
            ST_RED:
            begin
                strobe_next              = 1'b1;
                result_next.word_address = {1'b1, word_reg};
                result_next.nibble       = red_nib_reg;
                result_next.last         = 1'b1;
                state_next               = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg  <= result_next;
        red_nib_reg <= red_nib_next;
        if (accept)
        begin
            req_reg      <= request;
            chip_reg     <= in_chip;
            word_reg     <= in_word;
            mask_reg     <= bit_mask(request.y);
            in_range_reg <= (request.x <= max_x) && (request.y <= max_y);
            chip_ok_reg  <= ({1'b0, in_chip} < NUM_CHIPS_L);
        end
    end

endmodule

FILE: design/bicolor_matrix_pixel_plot.sv
// Top level of the bicolor matrix pixel plotter: config registers, plane RAMs, sequencer.
// Results: the request and the plane RAM read data are registered, then the sequencer
//   registers each result; a color change gives the green write then the red write.
// Busy: a plot that changes the pixel holds busy through the CALC and RED states, any
//   other request through CALC alone; no new request is taken until the sequencer is idle.
// Reset: max_x and max_y return to 63 and 15; busy stays high while both planes are
//   swept to zero. Results carry a strobe and cannot be stalled.
module bicolor_matrix_pixel_plot #(
    parameter int NUM_CHIPS      = bmpp_pkg::NUM_CHIPS_DEF,
    parameter int WORDS_PER_CHIP = bmpp_pkg::WORDS_PER_CHIP_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  bmpp_pkg::in_item_t                   request,
    output logic                                 result_strobe,
    output bmpp_pkg::out_item_t                  result,
    input  logic                                 cfg_we,
    input  logic [bmpp_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [bmpp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import bmpp_pkg::*;

    // Each plane gets its own RAM so both bits of a pixel are read and written together.
    localparam int PLANE_DEPTH = NUM_CHIPS * (WORDS_PER_CHIP / 2);
    localparam int AW          = $clog2(PLANE_DEPTH);

    logic [5:0]    max_x_reg;
    logic [3:0]    max_y_reg;

    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic          we;
    logic [3:0]    rdata_green, rdata_red;
    logic [3:0]    wdata_green, wdata_red;

    // Hold the coordinate limits; a write takes effect at once, no handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg <= 6'd63;
            max_y_reg <= 4'd15;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_MAX_X: max_x_reg <= cfg_wdata[5:0];
                CFG_MAX_Y: max_y_reg <= cfg_wdata[3:0];
                default:   ;
            endcase
        end
    end

    // Green plane: word addresses 0-31 of every chip.
    bmpp_ram #(
        .WIDTH (NIBBLE_W),
        .DEPTH (PLANE_DEPTH)
    ) u_ram_green (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata_green),
        .raddr (raddr),
        .rdata (rdata_green)
    );

    // Red plane: word addresses 32-63 of every chip.
    bmpp_ram #(
        .WIDTH (NIBBLE_W),
        .DEPTH (PLANE_DEPTH)
    ) u_ram_red (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata_red),
        .raddr (raddr),
        .rdata (rdata_red)
    );

    // Sequence each request: read both planes, compare, write back a changed pixel, emit results.
    bmpp_ctrl #(
        .NUM_CHIPS (NUM_CHIPS),
        .AW        (AW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .max_x         (max_x_reg),
        .max_y         (max_y_reg),
        .raddr         (raddr),
        .rdata_green   (rdata_green),
        .rdata_red     (rdata_red),
        .we            (we),
        .waddr         (waddr),
        .wdata_green   (wdata_green),
        .wdata_red     (wdata_red),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule
